FILE: hdl/assert_macros.svh
// Assertion helpers shared by the RTL. Each check runs on clk and stays quiet during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge while out of reset.
`define RDE_CHECK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition implies a property in the next cycle.
`define RDE_CHECK_NEXT(name, cond, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

FILE: hdl/rde_pkg.sv
`timescale 1ns / 1ps
package rde_pkg;

  localparam int DIM_W      = 13;
  localparam int CW         = 20;
  localparam int STEP_W     = 17;
  localparam int CFG_IDX_W  = 1;
  localparam int Q_DEPTH    = 2;
  localparam int MAX_WIDTH  = 128;
  localparam int MAX_HEIGHT = 128;
  localparam logic [7:0] DIM_RESET = 8'd128;
  localparam logic [7:0] OPAQUE    = 8'd255;

  localparam logic [2:0] CMD_WRITE = 3'd0;
  localparam logic [2:0] CMD_READ  = 3'd1;
  localparam logic [2:0] CMD_FILL  = 3'd2;
  localparam logic [2:0] CMD_LINE  = 3'd3;
  localparam logic [2:0] CMD_CLEAR = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [15:0] x_start;
    logic signed [15:0] y_start;
    logic signed [15:0] x_end;
    logic signed [15:0] y_end;
    logic signed [15:0] size_w;
    logic signed [15:0] size_h;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         alpha;
  } cmd_t;

  typedef struct packed {
    logic [7:0] read_red;
    logic [7:0] read_green;
    logic [7:0] read_blue;
    logic [7:0] read_alpha;
    logic       in_range;
  } res_t;

  typedef enum logic [2:0] {
    JOB_NONE,
    JOB_WRITE,
    JOB_READ,
    JOB_RECT,
    JOB_LINE
  } job_kind_t;

  typedef struct packed {
    job_kind_t             kind;
    logic                  res_inr;
    logic                  res_a255;
    logic signed [CW-1:0]  ox;
    logic signed [CW-1:0]  oy;
    logic signed [CW-1:0]  sw;
    logic signed [CW-1:0]  sh;
    logic signed [CW-1:0]  dx;
    logic signed [CW-1:0]  dy;
    logic [STEP_W-1:0]     steps;
    logic [31:0]           color;
  } job_t;

  typedef struct packed {
    logic [1:0] count;
    logic       full;
    logic       empty;
  } q_stat_t;

  typedef struct packed {
    logic busy;
  } b_stat_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_STEP,
    B_CLIP,
    B_BASE,
    B_WALK,
    B_RDATA
  } bstate_t;

  function automatic logic signed [CW-1:0] sx16(input logic [15:0] v);
    return {{(CW-16){v[15]}}, v};
  endfunction

endpackage

FILE: hdl/rde_front.sv
`timescale 1ns / 1ps
module rde_front (
  input  rde_pkg::cmd_t            cmd,
  input  logic [rde_pkg::DIM_W-1:0] w_eff,
  input  logic [rde_pkg::DIM_W-1:0] h_eff,
  output rde_pkg::job_t            job
);

  logic signed [rde_pkg::CW-1:0] xs, ys, xe, ye, sw, sh, dx, dy, adx, ady, ws, hs;
  logic in_img;

  always_comb begin
    xs  = rde_pkg::sx16(cmd.x_start);
    ys  = rde_pkg::sx16(cmd.y_start);
    xe  = rde_pkg::sx16(cmd.x_end);
    ye  = rde_pkg::sx16(cmd.y_end);
    sw  = rde_pkg::sx16(cmd.size_w);
    sh  = rde_pkg::sx16(cmd.size_h);
    ws  = $signed({{(rde_pkg::CW-rde_pkg::DIM_W){1'b0}}, w_eff});
    hs  = $signed({{(rde_pkg::CW-rde_pkg::DIM_W){1'b0}}, h_eff});
    dx  = xe - xs;
    dy  = ye - ys;
    adx = dx[rde_pkg::CW-1] ? -dx : dx;
    ady = dy[rde_pkg::CW-1] ? -dy : dy;
    in_img = !xs[rde_pkg::CW-1] && !ys[rde_pkg::CW-1] && (xs < ws) && (ys < hs);

    job          = '0;
    job.kind     = rde_pkg::JOB_NONE;
    job.color    = {cmd.alpha, cmd.blue, cmd.green, cmd.red};
    job.ox       = xs;
    job.oy       = ys;
    job.dx       = dx;
    job.dy       = dy;
    job.steps    = (adx > ady) ? adx[rde_pkg::STEP_W-1:0] : ady[rde_pkg::STEP_W-1:0];
    job.sw       = sw;
    job.sh       = sh;
    case (cmd.command)
      rde_pkg::CMD_WRITE: begin
        job.kind    = in_img ? rde_pkg::JOB_WRITE : rde_pkg::JOB_NONE;
        job.res_inr = in_img;
        job.sw      = rde_pkg::CW'(1);
        job.sh      = rde_pkg::CW'(1);
      end
      rde_pkg::CMD_READ: begin
        job.kind     = in_img ? rde_pkg::JOB_READ : rde_pkg::JOB_NONE;
        job.res_inr  = in_img;
        job.res_a255 = !in_img;
        job.sw       = rde_pkg::CW'(1);
        job.sh       = rde_pkg::CW'(1);
      end
      rde_pkg::CMD_FILL: begin
        job.kind = rde_pkg::JOB_RECT;
      end
      rde_pkg::CMD_LINE: begin
        job.kind = rde_pkg::JOB_LINE;
        job.sh   = sw;
      end
      rde_pkg::CMD_CLEAR: begin
        job.kind = rde_pkg::JOB_RECT;
        job.ox   = '0;
        job.oy   = '0;
        job.sw   = ws;
        job.sh   = hs;
      end
      default: begin
        job.kind = rde_pkg::JOB_NONE;
      end
    endcase
  end

endmodule

FILE: hdl/rde_fifo.sv
`timescale 1ns / 1ps
module rde_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rde_pkg::job_t     push_data,
  input  logic              pop,
  output rde_pkg::job_t     head,
  output rde_pkg::q_stat_t  stat
);

  rde_pkg::job_t entry [rde_pkg::Q_DEPTH];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_data;
  end

  assign head       = entry[rd_ptr];
  assign stat.count = count;
  assign stat.full  = (count == 2'(rde_pkg::Q_DEPTH));
  assign stat.empty = (count == 2'd0);

endmodule

FILE: hdl/rde_back.sv
`timescale 1ns / 1ps
module rde_back #(
  parameter int MAX_WIDTH  = rde_pkg::MAX_WIDTH,
  parameter int MAX_HEIGHT = rde_pkg::MAX_HEIGHT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [rde_pkg::DIM_W-1:0] w_eff,
  input  logic [rde_pkg::DIM_W-1:0] h_eff,
  input  rde_pkg::q_stat_t          q_stat,
  input  rde_pkg::job_t             head,
  output logic                      pop,
  output logic                      res_valid,
  input  logic                      res_stall,
  output rde_pkg::res_t             res,
  output rde_pkg::b_stat_t          stat
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = rde_pkg::CW;
  localparam int DW    = rde_pkg::DIM_W;

  rde_pkg::bstate_t state, state_next;
  rde_pkg::job_t    job;

  logic [31:0] frame [DEPTH];
  logic [31:0] rdata;

  logic signed [CW-1:0] qx, qy, rx, ry, ox, oy;
  logic [rde_pkg::STEP_W-1:0] cnt;
  logic [DW-1:0] x0, x1, y0, y1, cx, cy;
  logic [AW-1:0] rowbase, addr;

  logic signed [CW-1:0] ws, hs, steps_s;
  logic signed [CW-1:0] rxs, rys, rxn, ryn, qxn, qyn;
  logic signed [CW-1:0] x0s, x1s, y0s, y1s, sumx, sumy;
  logic [2*DW-1:0] prod;
  logic stop, nonempty, last, rect_done, fin, we;

  always_comb begin
    ws      = $signed({{(CW-DW){1'b0}}, w_eff});
    hs      = $signed({{(CW-DW){1'b0}}, h_eff});
    steps_s = $signed({{(CW-rde_pkg::STEP_W){1'b0}}, job.steps});

    // next line point, remainder kept in [0, steps)
    rxs = rx + job.dx;
    rys = ry + job.dy;
    rxn = rxs;
    qxn = qx;
    if (rxs >= steps_s) begin
      rxn = rxs - steps_s;
      qxn = qx + CW'(1);
    end else if (rxs[CW-1]) begin
      rxn = rxs + steps_s;
      qxn = qx - CW'(1);
    end
    ryn = rys;
    qyn = qy;
    if (rys >= steps_s) begin
      ryn = rys - steps_s;
      qyn = qy + CW'(1);
    end else if (rys[CW-1]) begin
      ryn = rys + steps_s;
      qyn = qy - CW'(1);
    end
    stop = qxn[CW-1] || qyn[CW-1] || (qxn > ws) || (qyn > hs) ||
           ((qxn == ws) && (rxn != '0)) || ((qyn == hs) && (ryn != '0));

    // clip the current rectangle to the image
    sumx = ox + job.sw;
    sumy = oy + job.sh;
    x0s  = ox[CW-1] ? '0 : ox;
    y0s  = oy[CW-1] ? '0 : oy;
    x1s  = (sumx < ws) ? sumx : ws;
    y1s  = (sumy < hs) ? sumy : hs;
    nonempty = (job.sw > 0) && (job.sh > 0) && (x0s < x1s) && (y0s < y1s);

    prod = y0 * w_eff;
    addr = rowbase + AW'(cx);
    last = (cx == x1 - DW'(1)) && (cy == y1 - DW'(1));
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    fin        = 1'b0;
    we         = 1'b0;
    rect_done  = 1'b0;
    case (state)
      rde_pkg::B_IDLE: begin
        if (!q_stat.empty && !res_valid) begin
          pop = 1'b1;
          if (head.kind == rde_pkg::JOB_NONE) fin = 1'b1;
          else if (head.kind == rde_pkg::JOB_LINE) begin
            if (head.steps == '0) fin = 1'b1;
            else state_next = rde_pkg::B_STEP;
          end else state_next = rde_pkg::B_CLIP;
        end
      end
      rde_pkg::B_STEP: begin
        if (stop) begin
          fin        = 1'b1;
          state_next = rde_pkg::B_IDLE;
        end else state_next = rde_pkg::B_CLIP;
      end
      rde_pkg::B_CLIP: begin
        if (nonempty) state_next = rde_pkg::B_BASE;
        else rect_done = 1'b1;
      end
      rde_pkg::B_BASE: begin
        state_next = rde_pkg::B_WALK;
      end
      rde_pkg::B_WALK: begin
        if (job.kind == rde_pkg::JOB_READ) state_next = rde_pkg::B_RDATA;
        else begin
          we = 1'b1;
          if (last) rect_done = 1'b1;
        end
      end
      rde_pkg::B_RDATA: begin
        state_next = rde_pkg::B_IDLE;
      end
      default: begin
        state_next = rde_pkg::B_IDLE;
      end
    endcase
    if (rect_done) begin
      if (job.kind == rde_pkg::JOB_LINE && cnt != '0) state_next = rde_pkg::B_STEP;
      else begin
        fin        = 1'b1;
        state_next = rde_pkg::B_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= rde_pkg::B_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    case (state)
      rde_pkg::B_IDLE: begin
        if (pop) begin
          job <= head;
          ox  <= head.ox;
          oy  <= head.oy;
          qx  <= head.ox;
          qy  <= head.oy;
          rx  <= '0;
          ry  <= '0;
          cnt <= head.steps;
        end
      end
      rde_pkg::B_STEP: begin
        qx  <= qxn;
        qy  <= qyn;
        rx  <= rxn;
        ry  <= ryn;
        ox  <= qxn;
        oy  <= qyn;
        cnt <= cnt - rde_pkg::STEP_W'(1);
      end
      rde_pkg::B_CLIP: begin
        x0 <= x0s[DW-1:0];
        x1 <= x1s[DW-1:0];
        y0 <= y0s[DW-1:0];
        y1 <= y1s[DW-1:0];
      end
      rde_pkg::B_BASE: begin
        rowbase <= prod[AW-1:0];
        cx      <= x0;
        cy      <= y0;
      end
      rde_pkg::B_WALK: begin
        // advance across the row, then wrap to the next one
        if (cx == x1 - DW'(1)) begin
          cx      <= x0;
          cy      <= cy + DW'(1);
          rowbase <= rowbase + AW'(w_eff);
        end else cx <= cx + DW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) frame[addr] <= job.color;
    rdata <= frame[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == rde_pkg::B_RDATA) begin
      res_valid      <= 1'b1;
      res.read_red   <= rdata[7:0];
      res.read_green <= rdata[15:8];
      res.read_blue  <= rdata[23:16];
      res.read_alpha <= rdata[31:24];
      res.in_range   <= 1'b1;
    end else if (fin) begin
      res_valid      <= 1'b1;
      res.read_red   <= '0;
      res.read_green <= '0;
      res.read_blue  <= '0;
      // a pop that finishes at once takes its flags from the queue head
      res.read_alpha <= ((pop ? head.res_a255 : job.res_a255)) ? rde_pkg::OPAQUE : 8'd0;
      res.in_range   <= pop ? head.res_inr : job.res_inr;
    end else if (res_valid && !res_stall) begin
      res_valid <= 1'b0;
    end
  end

  assign stat.busy = (state != rde_pkg::B_IDLE) || pop;

endmodule

FILE: hdl/raster_draw_engine_core.sv
`timescale 1ns / 1ps
// Channel   Handshake            Word
// cmd       cmd_valid/cmd_stall  rde_pkg::cmd_t, one drawing command
// res       res_valid/res_stall  rde_pkg::res_t, one result per command
// cfg       cfg_valid/cfg_ready  cfg_index, cfg_data (image width, height)
//
// A command that does nothing (unknown, pixel off the image, zero-length line) ends when it is popped;
// a pixel write passes the clip, base and walk states, a read also the read-data state. Fill and
// clear walk the clipped box pixel by pixel and stop after the clip when the box is empty. A line steps
// to each point and fills the clipped brush area there; a point off the image ends it.
// Reset (rst, synchronous) sets both dimensions to 128; the frame memory is not cleared.
// A two-word queue lets commands enter while the drawing side or res_stall holds.
module raster_draw_engine_core #(
  parameter int MAX_WIDTH  = rde_pkg::MAX_WIDTH,
  parameter int MAX_HEIGHT = rde_pkg::MAX_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_stall,
  input  rde_pkg::cmd_t                 cmd,
  output logic                          res_valid,
  input  logic                          res_stall,
  output rde_pkg::res_t                 res,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rde_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data
);

`include "assert_macros.svh"

  logic [7:0] image_width, image_height;
  logic [rde_pkg::DIM_W-1:0] w_eff, h_eff;
  rde_pkg::job_t    job, head;
  rde_pkg::q_stat_t q_stat;
  rde_pkg::b_stat_t b_stat;
  logic pop, push;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= rde_pkg::DIM_RESET;
      image_height <= rde_pkg::DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rde_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        rde_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // saturate to the frame memory size
  always_comb begin
    w_eff = ({5'b0, image_width} > rde_pkg::DIM_W'(MAX_WIDTH)) ?
            rde_pkg::DIM_W'(MAX_WIDTH) : {5'b0, image_width};
    h_eff = ({5'b0, image_height} > rde_pkg::DIM_W'(MAX_HEIGHT)) ?
            rde_pkg::DIM_W'(MAX_HEIGHT) : {5'b0, image_height};
  end

  assign cmd_stall = q_stat.full;
  assign push      = cmd_valid && !cmd_stall;

  rde_front u_front (
    .cmd   (cmd),
    .w_eff (w_eff),
    .h_eff (h_eff),
    .job   (job)
  );

  rde_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (job),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  rde_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .w_eff     (w_eff),
    .h_eff     (h_eff),
    .q_stat    (q_stat),
    .head      (head),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .stat      (b_stat)
  );

  `RDE_CHECK(a_queue_bound, q_stat.count <= 2'(rde_pkg::Q_DEPTH), "queue overflow")
  `RDE_CHECK(a_res_from_work, $rose(res_valid) |-> $past(b_stat.busy), "result without work")
  `RDE_CHECK_NEXT(a_push_lands, push, (q_stat.count != 2'd0) || b_stat.busy || res_valid, "command lost")

endmodule
